/* sv/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// Item types, command codes and round constants for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // entry 0 is H0
  localparam logic [7:0][31:0] HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

/* sv/sha256_byte_stream_hasher_core.sv */
// Absorb item: one byte is taken; when it fills a block, 64 rounds and the chain add follow.
// Finish item: padding bytes plus one or two compressions,
// then 8 digest words, one per cycle while out_ready is high.
// One round per cycle through a single round unit; in_ready is low during all of it.
// Synchronous active-low reset loads the initial hash and clears counts and control.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// SHA-256 of a byte stream: byte absorb, padding, iterative compression and
// digest output as eight 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire sha256_pkg::in_item_t  in_item,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [1:0] PH_MSG  = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [5:0]        rnd_r, rnd_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [63:0]       bit_len_r, bit_len_nxt;
  logic [7:0][31:0]  chain_r, chain_nxt;
  logic [7:0][31:0]  v_r, v_nxt;
  logic [511:0]      w_r, w_nxt;

  logic        ins;
  logic [7:0]  ins_byte;
  logic [31:0] t1, t2, w_new;

  // w_r holds the 16-word schedule window, oldest word at the top
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    rnd_nxt     = rnd_r;
    pos_nxt     = pos_r;
    bit_len_nxt = bit_len_r;
    chain_nxt   = chain_r;
    v_nxt       = v_r;
    w_nxt       = w_r;
    ins         = 1'b0;
    ins_byte    = 8'h00;

    w_new = small_sigma1(w_r[63:32]) + w_r[223:192]
          + small_sigma0(w_r[479:448]) + w_r[511:480];
    t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + round_k(rnd_r) + w_r[511:480];
    t2 = big_sigma0(v_r[0])
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.cmd == CMD_ABSORB) begin
            ins         = 1'b1;
            ins_byte    = in_item.data_byte;
            bit_len_nxt = bit_len_r + 64'd8;
          end else begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        ins = 1'b1;
        case (phase_r)
          PH_MSG: begin
            ins_byte  = 8'h80;
            phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (pos_r == 6'd56) begin
              ins_byte    = bit_len_r[63:56];
              bit_len_nxt = {bit_len_r[55:0], 8'h00};
              phase_nxt   = PH_LEN;
              cnt_nxt     = 3'd1;
            end
          end
          PH_LEN: begin
            ins_byte    = bit_len_r[63:56];
            bit_len_nxt = {bit_len_r[55:0], 8'h00};
            cnt_nxt     = cnt_r + 3'd1;
            if (cnt_r == 3'd7) begin
              phase_nxt = PH_DONE;
            end
          end
          default: ins = 1'b0;
        endcase
      end
      S_ROUND: begin
        v_nxt   = {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
        w_nxt   = {w_r[479:0], w_new};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        if (phase_r == PH_DONE) begin
          state_nxt = S_OUT;
          cnt_nxt   = 3'd0;
        end else if (phase_r == PH_MSG) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            chain_nxt   = HASH_INIT;
            bit_len_nxt = 64'd0;
            phase_nxt   = PH_MSG;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // byte insertion; a full block starts the rounds
    if (ins) begin
      w_nxt   = {w_r[503:0], ins_byte};
      pos_nxt = pos_r + 6'd1;
      if (pos_r == 6'd63) begin
        state_nxt = S_ROUND;
        rnd_nxt   = 6'd0;
        v_nxt     = chain_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_MSG;
      cnt_r     <= 3'd0;
      rnd_r     <= 6'd0;
      pos_r     <= 6'd0;
      bit_len_r <= 64'd0;
      chain_r   <= HASH_INIT;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      rnd_r     <= rnd_nxt;
      pos_r     <= pos_nxt;
      bit_len_r <= bit_len_nxt;
      chain_r   <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_item.digest_word = chain_r[cnt_r];
    out_item.word_index  = cnt_r;
    out_item.last_word   = (cnt_r == 3'd7);
  end

endmodule

`default_nettype wire
